@@ rtl/core/ppu_pkg.sv @@
`timescale 1ns / 1ps
package ppu_pkg;

    localparam logic [1:0] MODE_EMIT  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_REC = 1'b1;

    localparam int QUOT_W = 17;

    typedef logic [2:0][15:0] vec_t;
    typedef logic [3:0][11:0] col_t;

    // One pool slot as kept in the slot memory
    typedef struct packed {
        vec_t        pos;
        vec_t        vel;
        vec_t        acc;
        vec_t        scale_b;
        vec_t        scale_e;
        col_t        col_b;
        col_t        col_e;
        vec_t        spin;
        vec_t        rot;
        logic [15:0] age;
        logic [15:0] life;
        logic [15:0] drag;
    } entry_t;

    // One result word
    typedef struct packed {
        logic        kind;
        logic [5:0]  slot;
        logic        full;
        vec_t        pos;
        vec_t        scale;
        col_t        col;
        vec_t        rot;
    } rec_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_status_t;

    function automatic logic [15:0] sat16(input logic signed [40:0] x);
        logic [15:0] r;
        if (x > 41'sd32767)
            r = 16'h7FFF;
        else if (x < -41'sd32768)
            r = 16'h8000;
        else
            r = x[15:0];
        return r;
    endfunction

endpackage

@@ rtl/core/ppu_div.sv @@
`timescale 1ns / 1ps
module ppu_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [32:0]         dividend,
    input  logic [15:0]         divisor,
    output ppu_pkg::div_status_t status
);
    import ppu_pkg::*;

    // Dividend is known to be below divisor * 2^17, so 17 quotient bits suffice
    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [16:0]       rem_reg;
    logic [16:0]       low_reg;
    logic [QUOT_W-1:0] q_reg;
    logic [15:0]       dsr_reg;
    logic [17:0]       trial;
    logic              qbit;

    assign trial = {rem_reg, low_reg[16]};
    assign qbit  = (trial >= {2'b00, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(QUOT_W);
                rem_reg  <= {1'b0, dividend[32:17]};
                low_reg  <= dividend[16:0];
                q_reg    <= '0;
                dsr_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                // Shift in one dividend bit, subtract when it fits
                rem_reg <= qbit ? 17'(trial - {2'b00, dsr_reg}) : trial[16:0];
                low_reg <= {low_reg[15:0], 1'b0};
                q_reg   <= {q_reg[QUOT_W-2:0], qbit};
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign status.quot = q_reg;

endmodule

@@ rtl/core/particle_pool_update.sv @@
`timescale 1ns / 1ps
// Channel  | Signals                         | Word
// ---------+---------------------------------+-------------------------------------------
// in       | s_tvalid s_tready s_tdata s_tuser | one command: emit, tick or clear
// out      | m_tvalid m_tready m_tdata m_tuser m_tlast | emit acknowledge or particle record
//
// Emit scans the live flags one slot per cycle and claims the first free slot; its ack
// goes out once the output register is free. Tick visits every slot: it skips a dead
// one, retires an expired one and updates a survivor with the shared 18x22 multiplier and
// the 17-step divider (7 interpolation divides). Clear and reset empty the pool at once.
// The block takes no new word until the current one finishes; a stalled output
// holds the sequencer whenever a finished record needs the output register.
module particle_pool_update
#(
    parameter int POOL_SIZE = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // position, velocity, accel, scale_begin, scale_finish, colour_begin,
    // colour_finish, spin_rate, lifetime_or_step, drag, start_angle
    input  logic [463:0] s_tdata,
    // mode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot, pool_full, cur_position, cur_scale, cur_colour, cur_rotation, pad
    output logic [199:0] m_tdata,
    // result_kind
    output logic         m_tuser,
    output logic         m_tlast
);
    import ppu_pkg::*;

    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CW = $clog2(POOL_SIZE + 1) + 1;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SCAN = 9'b000000010,
        ST_LOAD = 9'b000000100,
        ST_MUL  = 9'b000001000,
        ST_USE  = 9'b000010000,
        ST_DIV  = 9'b000100000,
        ST_DONE = 9'b001000000,
        ST_FIN  = 9'b010000000,
        ST_ACK  = 9'b100000000
    } state_t;

    typedef enum logic [2:0] {
        OP_FACT, OP_DAMP, OP_ACC, OP_VEL, OP_SPIN, OP_LERP
    } op_t;

    state_t               state_reg;
    op_t                  op_reg;
    logic [CW-1:0]        cnt_reg;
    logic [1:0]           comp_reg;
    logic [2:0]           lane_reg;
    logic [POOL_SIZE-1:0] alive_reg;
    logic [1:0]           mode_reg;
    logic [463:0]         in_reg;
    logic                 full_reg;
    entry_t               ent_reg;
    entry_t               mem_q;
    entry_t               new_ent;
    entry_t               load_ent;
    entry_t               mem [POOL_SIZE];
    logic [20:0]          factor_reg;
    logic signed [39:0]   prod_reg;
    logic                 neg_reg;
    logic signed [16:0]   begin_reg;
    vec_t                 sc_reg;
    col_t                 col_reg;
    rec_t                 pend_reg;
    logic                 pend_valid_reg;
    rec_t                 out_reg;
    logic                 out_last_reg;
    logic                 m_valid_reg;

    logic [AW-1:0]        idx;
    logic                 out_free;
    logic                 out_load;
    logic signed [17:0]   mul_a;
    logic signed [21:0]   mul_b;
    logic signed [16:0]   lane_b;
    logic signed [16:0]   lane_e;
    logic signed [40:0]   prod_x;
    logic signed [40:0]   rnd8;
    logic signed [40:0]   rnd20;
    logic [39:0]          mag;
    logic [32:0]          dividend;
    logic                 div_start;
    div_status_t          div_st;
    logic signed [18:0]   lerp_res;
    logic [16:0]          age_sum;
    logic [15:0]          age_new;
    rec_t                 rec_now;
    rec_t                 ack_now;

    assign idx      = cnt_reg[AW-1:0];
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // Load the output register whenever a finished word moves into it
    assign out_load = out_free && (((state_reg == ST_DONE || state_reg == ST_FIN) &&
                                    pend_valid_reg) || state_reg == ST_ACK);

    // Unpack the held command into a slot record
    assign new_ent.pos     = in_reg[47:0];
    assign new_ent.vel     = in_reg[95:48];
    assign new_ent.acc     = in_reg[143:96];
    assign new_ent.scale_b = in_reg[191:144];
    assign new_ent.scale_e = in_reg[239:192];
    assign new_ent.col_b   = in_reg[287:240];
    assign new_ent.col_e   = in_reg[335:288];
    assign new_ent.spin    = in_reg[383:336];
    assign new_ent.life    = in_reg[399:384];
    assign new_ent.drag    = in_reg[415:400];
    assign new_ent.rot     = in_reg[463:416];
    assign new_ent.age     = 16'd0;

    // Slot as read back, with its age advanced
    always_comb
    begin
        load_ent     = mem_q;
        load_ent.age = age_new;
    end

    // Interpolation end points: lanes 0..2 scale, 3..6 colour
    always_comb
    begin
        if (lane_reg < 3'd3)
        begin
            lane_b = $signed({ent_reg.scale_b[lane_reg[1:0]][15],
                              ent_reg.scale_b[lane_reg[1:0]]});
            lane_e = $signed({ent_reg.scale_e[lane_reg[1:0]][15],
                              ent_reg.scale_e[lane_reg[1:0]]});
        end
        else
        begin
            lane_b = $signed({5'd0, ent_reg.col_b[2'(lane_reg - 3'd3)]});
            lane_e = $signed({5'd0, ent_reg.col_e[2'(lane_reg - 3'd3)]});
        end
    end

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = $signed({6'd0, in_reg[399:384]});
        case (op_reg)
            OP_FACT:
            begin
                mul_a = $signed({2'b00, ent_reg.drag});
            end
            OP_DAMP:
            begin
                mul_a = $signed({{2{ent_reg.vel[comp_reg][15]}}, ent_reg.vel[comp_reg]});
                mul_b = $signed({1'b0, factor_reg});
            end
            OP_ACC:
            begin
                mul_a = $signed({{2{ent_reg.acc[comp_reg][15]}}, ent_reg.acc[comp_reg]});
            end
            OP_VEL:
            begin
                mul_a = $signed({{2{ent_reg.vel[comp_reg][15]}}, ent_reg.vel[comp_reg]});
            end
            OP_SPIN:
            begin
                mul_a = $signed({{2{ent_reg.spin[comp_reg][15]}}, ent_reg.spin[comp_reg]});
            end
            OP_LERP:
            begin
                mul_a = 18'(lane_e) - 18'(lane_b);
                mul_b = $signed({6'd0, ent_reg.age});
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign prod_x = {prod_reg[39], prod_reg};
    assign rnd8   = (prod_x + 41'sd128) >>> 8;
    assign rnd20  = (prod_x + 41'sd524288) >>> 20;

    // Magnitude of the interpolation product plus half the divisor for rounding
    assign mag       = prod_reg[39] ? 40'(-prod_reg) : prod_reg;
    assign dividend  = 33'(mag[32:0] + {18'd0, ent_reg.life[15:1]});
    assign div_start = (state_reg == ST_USE) && (op_reg == OP_LERP);
    assign lerp_res  = neg_reg ? (19'(begin_reg) - $signed({2'b00, div_st.quot}))
                               : (19'(begin_reg) + $signed({2'b00, div_st.quot}));

    assign age_sum = {1'b0, mem_q.age} + {1'b0, in_reg[399:384]};
    assign age_new = age_sum[16] ? 16'hFFFF : age_sum[15:0];

    assign rec_now.kind  = KIND_REC;
    assign rec_now.slot  = 6'(cnt_reg);
    assign rec_now.full  = 1'b0;
    assign rec_now.pos   = ent_reg.pos;
    assign rec_now.scale = sc_reg;
    assign rec_now.col   = col_reg;
    assign rec_now.rot   = ent_reg.rot;

    assign ack_now.kind  = KIND_ACK;
    assign ack_now.slot  = full_reg ? 6'd0 : 6'(cnt_reg);
    assign ack_now.full  = full_reg;
    assign ack_now.pos   = full_reg ? '0 : new_ent.pos;
    assign ack_now.scale = full_reg ? '0 : new_ent.scale_b;
    assign ack_now.col   = full_reg ? '0 : new_ent.col_b;
    assign ack_now.rot   = full_reg ? '0 : new_ent.rot;

    ppu_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (ent_reg.life),
        .status   (div_st)
    );

    // Slot memory: registered read at the scan address, write on emit or write-back
    always_ff @(posedge clk)
    begin
        mem_q <= mem[idx];
        if (state_reg == ST_SCAN && mode_reg == MODE_EMIT &&
            cnt_reg < CW'(POOL_SIZE) && !alive_reg[idx])
        begin
            mem[idx] <= new_ent;
        end
        else if (state_reg == ST_DONE && (!pend_valid_reg || out_free))
        begin
            mem[idx] <= ent_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_FACT;
            cnt_reg        <= '0;
            comp_reg       <= 2'd0;
            lane_reg       <= 3'd0;
            alive_reg      <= '0;
            mode_reg       <= MODE_EMIT;
            full_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        in_reg   <= s_tdata;
                        mode_reg <= s_tuser;
                        cnt_reg  <= '0;
                        if (s_tuser == MODE_EMIT || s_tuser == MODE_TICK)
                            state_reg <= ST_SCAN;
                        else if (s_tuser == MODE_CLEAR)
                            alive_reg <= '0;
                    end
                end
                ST_SCAN:
                begin
                    if (cnt_reg >= CW'(POOL_SIZE))
                    begin
                        full_reg  <= 1'b1;
                        state_reg <= (mode_reg == MODE_EMIT) ? ST_ACK : ST_FIN;
                    end
                    else if (mode_reg == MODE_EMIT)
                    begin
                        if (!alive_reg[idx])
                        begin
                            alive_reg[idx] <= 1'b1;
                            full_reg       <= 1'b0;
                            state_reg      <= ST_ACK;
                        end
                        else
                            cnt_reg <= cnt_reg + 1'b1;
                    end
                    else if (alive_reg[idx])
                        state_reg <= ST_LOAD;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                ST_LOAD:
                begin
                    // Age the particle; retire it when age reaches life
                    if (age_new >= mem_q.life)
                    begin
                        alive_reg[idx] <= 1'b0;
                        cnt_reg        <= cnt_reg + 1'b1;
                        state_reg      <= ST_SCAN;
                    end
                    else
                    begin
                        ent_reg     <= load_ent;
                        op_reg      <= OP_FACT;
                        comp_reg    <= 2'd0;
                        lane_reg    <= 3'd0;
                        state_reg   <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= 40'(mul_a * mul_b);
                    state_reg <= ST_USE;
                end
                ST_USE:
                begin
                    case (op_reg)
                        OP_FACT:
                        begin
                            factor_reg <= (prod_reg >= 40'sd1048576) ? 21'd0
                                        : 21'(21'd1048576 - prod_reg[20:0]);
                            op_reg    <= (ent_reg.drag != 16'd0) ? OP_DAMP : OP_ACC;
                            state_reg <= ST_MUL;
                        end
                        OP_DAMP:
                        begin
                            ent_reg.vel[comp_reg] <= sat16(rnd20);
                            op_reg    <= OP_ACC;
                            state_reg <= ST_MUL;
                        end
                        OP_ACC:
                        begin
                            ent_reg.vel[comp_reg] <= sat16(
                                $signed({{25{ent_reg.vel[comp_reg][15]}},
                                         ent_reg.vel[comp_reg]}) + rnd8);
                            op_reg    <= OP_VEL;
                            state_reg <= ST_MUL;
                        end
                        OP_VEL:
                        begin
                            ent_reg.pos[comp_reg] <= sat16(
                                $signed({{25{ent_reg.pos[comp_reg][15]}},
                                         ent_reg.pos[comp_reg]}) + rnd8);
                            op_reg    <= OP_SPIN;
                            state_reg <= ST_MUL;
                        end
                        OP_SPIN:
                        begin
                            ent_reg.rot[comp_reg] <= sat16(
                                $signed({{25{ent_reg.rot[comp_reg][15]}},
                                         ent_reg.rot[comp_reg]}) + rnd8);
                            if (comp_reg == 2'd2)
                                op_reg <= OP_LERP;
                            else
                            begin
                                comp_reg <= comp_reg + 2'd1;
                                op_reg   <= (ent_reg.drag != 16'd0) ? OP_DAMP : OP_ACC;
                            end
                            state_reg <= ST_MUL;
                        end
                        OP_LERP:
                        begin
                            neg_reg   <= prod_reg[39];
                            begin_reg <= lane_b;
                            state_reg <= ST_DIV;
                        end
                        default:
                        begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                ST_DIV:
                begin
                    if (div_st.done)
                    begin
                        if (lane_reg < 3'd3)
                            sc_reg[lane_reg[1:0]] <= sat16(41'(lerp_res));
                        else if (lerp_res < 19'sd0)
                            col_reg[2'(lane_reg - 3'd3)] <= 12'd0;
                        else if (lerp_res > 19'sd4095)
                            col_reg[2'(lane_reg - 3'd3)] <= 12'hFFF;
                        else
                            col_reg[2'(lane_reg - 3'd3)] <= lerp_res[11:0];
                        if (lane_reg == 3'd6)
                            state_reg <= ST_DONE;
                        else
                        begin
                            lane_reg  <= lane_reg + 3'd1;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_DONE:
                begin
                    // Hold the newest record back until we know whether it is the last
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_reg      <= pend_reg;
                            out_last_reg <= 1'b0;
                        end
                        pend_reg       <= rec_now;
                        pend_valid_reg <= 1'b1;
                        cnt_reg        <= cnt_reg + 1'b1;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_FIN:
                begin
                    if (!pend_valid_reg)
                        state_reg <= ST_IDLE;
                    else if (out_free)
                    begin
                        out_reg        <= pend_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_ACK:
                begin
                    if (out_free)
                    begin
                        out_reg      <= ack_now;
                        out_last_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_reg.rot, out_reg.col, out_reg.scale, out_reg.pos,
                       out_reg.full, out_reg.slot};

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !pend_valid_reg)
        else $error("record left pending while idle");

    a_load_live_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> alive_reg[idx])
        else $error("loading a slot that is not live");

    a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_st.busy || div_st.done))
        else $error("waiting on an idle divider");

    a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && out_reg.kind == KIND_ACK) |-> out_last_reg)
        else $error("acknowledge without last");
`endif

endmodule
